// ----- hw/rtl/topic_subscriber_dispatch_table_assert.svh -----
// assertion macros for the dispatch table
`ifndef TOPIC_SUBSCRIBER_DISPATCH_TABLE_ASSERT_SVH
`define TOPIC_SUBSCRIBER_DISPATCH_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TSDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TSDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tsdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tsdt_pkg;

  localparam int unsigned TOPICS_DEF = 256;
  localparam int unsigned SLOTS_DEF  = 8;

  localparam logic [1:0] MODE_SUB     = 2'd0;
  localparam logic [1:0] MODE_UNSUB   = 2'd1;
  localparam logic [1:0] MODE_PUB     = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_FULL     = 3'd1,
    RC_NOTFOUND = 3'd2,
    RC_DELIVERY = 3'd3,
    RC_NOMATCH  = 3'd4
  } rc_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  topic_index;
    logic [7:0]  group_id;
    logic [7:0]  subscriber_id;
    logic [3:0]  handler_tag;
    logic [31:0] payload;
  } in_t;

  typedef struct packed {
    rc_e         result_code;
    logic [7:0]  target_id;
    logic [3:0]  target_handler;
    logic [15:0] topic_word;
    logic [31:0] delivered_data;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] grp;
    logic [3:0] hnd;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tsdt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsdt_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/topic_subscriber_dispatch_table.sv -----
// subscribe shifts the stored entries up one slot, then writes the new one; unsubscribe scans, then shifts
// publish runs a match scan, then a second pass over the slots up to the last match
// the sequencer steps through the slots of a topic in a single entry memory, one slot at a time
// one request in flight, a result may wait in the output
// reset clears the sequencer, output valid and the per-topic count valid bits at once
`timescale 1ns / 1ps
`default_nettype none
`include "topic_subscriber_dispatch_table_assert.svh"

module topic_subscriber_dispatch_table #(
  parameter int unsigned TOPICS = tsdt_pkg::TOPICS_DEF,
  parameter int unsigned SLOTS  = tsdt_pkg::SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire tsdt_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output tsdt_pkg::out_t      out_o
);

  import tsdt_pkg::*;

  localparam int unsigned TIX_W  = $clog2(TOPICS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned ADDR_W = $clog2(TOPICS * SLOTS);
  localparam logic [ADDR_W-1:0] SLOTS_A = ADDR_W'(SLOTS);
  localparam logic [CNT_W-1:0]  SLOTS_C = CNT_W'(SLOTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CNT     = 4'd1;
  localparam logic [3:0] S_SUB_RD  = 4'd2;
  localparam logic [3:0] S_SUB_WR  = 4'd3;
  localparam logic [3:0] S_SUB_NEW = 4'd4;
  localparam logic [3:0] S_UN_RD   = 4'd5;
  localparam logic [3:0] S_UN_CHK  = 4'd6;
  localparam logic [3:0] S_SH_RD   = 4'd7;
  localparam logic [3:0] S_SH_WR   = 4'd8;
  localparam logic [3:0] S_P1_RD   = 4'd9;
  localparam logic [3:0] S_P1_CHK  = 4'd10;
  localparam logic [3:0] S_P2_RD   = 4'd11;
  localparam logic [3:0] S_P2_CHK  = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  logic [3:0]        state_q, state_d;
  in_t               req_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  lastk_q, lastk_d;
  logic              any_q, any_d;
  rc_e               rc_q, rc_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [TOPICS-1:0] vld_q;

  logic              out_valid_q;
  out_t              out_q, out_d;
  logic              out_load, out_free;

  logic              in_accept;
  logic [TIX_W-1:0]  tix;
  logic              topic_ok;

  logic              ent_re, ent_we;
  logic [ADDR_W-1:0] ent_raddr, ent_waddr;
  entry_t            ent_wdata, ent_rdata;

  logic              cnt_re, cnt_we;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_cur;

  logic [CNT_W:0]    idx_p1, idx_p2, cnt_x;
  logic              pub_match, un_match;
  logic [15:0]       topic_word;
  logic [31:0]       req_data;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign tix        = req_q.topic_index[TIX_W-1:0];
  assign topic_ok   = ({1'b0, req_q.topic_index} < 9'(TOPICS));
  assign cnt_cur    = vld_q[tix] ? cnt_rdata : '0;
  assign idx_p1     = {1'b0, idx_q} + (CNT_W+1)'(1);
  assign idx_p2     = {1'b0, idx_q} + (CNT_W+1)'(2);
  assign cnt_x      = {1'b0, cnt_q};
  assign pub_match  = (req_q.group_id == 8'd0) || (ent_rdata.grp == req_q.group_id);
  assign un_match   = (ent_rdata.id == req_q.subscriber_id);
  assign topic_word = {req_q.group_id, req_q.topic_index};
  assign req_data   = (req_q.mode == MODE_PUB) ? req_q.payload : 32'd0;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cnt_re = in_accept;

  tsdt_ram #(
    .DEPTH(TOPICS * SLOTS),
    .WIDTH($bits(entry_t))
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .re_i   (ent_re),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  tsdt_ram #(
    .DEPTH(TOPICS),
    .WIDTH(CNT_W)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(tix),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(in_i.topic_index[TIX_W-1:0]),
    .rdata_o(cnt_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    lastk_d   = lastk_q;
    any_d     = any_q;
    rc_d      = rc_q;
    base_d    = base_q;
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_raddr = base_q + ADDR_W'(idx_q);
    ent_waddr = base_q + ADDR_W'(idx_q);
    ent_wdata = ent_rdata;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_q - CNT_W'(1);
    out_load  = 1'b0;
    out_d     = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept && (in_i.mode != MODE_IGNORED)) begin
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        cnt_d  = cnt_cur;
        idx_d  = '0;
        any_d  = 1'b0;
        base_d = ADDR_W'(tix) * SLOTS_A;
        if (!topic_ok) begin
          state_d = S_EMIT;
          case (req_q.mode)
            MODE_SUB:   rc_d = RC_FULL;
            MODE_UNSUB: rc_d = RC_NOTFOUND;
            default:    rc_d = RC_NOMATCH;
          endcase
        end else begin
          case (req_q.mode)
            MODE_SUB: begin
              if (cnt_cur >= SLOTS_C) begin
                rc_d    = RC_FULL;
                state_d = S_EMIT;
              end else if (cnt_cur == '0) begin
                state_d = S_SUB_NEW;
              end else begin
                idx_d   = cnt_cur;
                state_d = S_SUB_RD;
              end
            end
            MODE_UNSUB: begin
              if (cnt_cur == '0) begin
                rc_d    = RC_NOTFOUND;
                state_d = S_EMIT;
              end else begin
                state_d = S_UN_RD;
              end
            end
            default: begin
              if (cnt_cur == '0) begin
                rc_d    = RC_NOMATCH;
                state_d = S_EMIT;
              end else begin
                state_d = S_P1_RD;
              end
            end
          endcase
        end
      end
      S_SUB_RD: begin
        ent_re    = 1'b1;
        ent_raddr = base_q + ADDR_W'(idx_q) - ADDR_W'(1);
        state_d   = S_SUB_WR;
      end
      S_SUB_WR: begin
        ent_we = 1'b1;
        if (idx_q == CNT_W'(1)) begin
          state_d = S_SUB_NEW;
        end else begin
          idx_d   = idx_q - CNT_W'(1);
          state_d = S_SUB_RD;
        end
      end
      S_SUB_NEW: begin
        ent_we    = 1'b1;
        ent_waddr = base_q;
        ent_wdata = '{id: req_q.subscriber_id, grp: req_q.group_id, hnd: req_q.handler_tag};
        cnt_we    = 1'b1;
        cnt_wdata = cnt_q + CNT_W'(1);
        rc_d      = RC_OK;
        state_d   = S_EMIT;
      end
      S_UN_RD: begin
        ent_re  = 1'b1;
        state_d = S_UN_CHK;
      end
      S_UN_CHK: begin
        if (un_match) begin
          if (idx_p1 == cnt_x) begin
            cnt_we  = 1'b1;
            rc_d    = RC_OK;
            state_d = S_EMIT;
          end else begin
            state_d = S_SH_RD;
          end
        end else if (idx_p1 == cnt_x) begin
          rc_d    = RC_NOTFOUND;
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_p1[CNT_W-1:0];
          state_d = S_UN_RD;
        end
      end
      S_SH_RD: begin
        ent_re    = 1'b1;
        ent_raddr = base_q + ADDR_W'(idx_q) + ADDR_W'(1);
        state_d   = S_SH_WR;
      end
      S_SH_WR: begin
        ent_we = 1'b1;
        if (idx_p2 == cnt_x) begin
          cnt_we  = 1'b1;
          rc_d    = RC_OK;
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_p1[CNT_W-1:0];
          state_d = S_SH_RD;
        end
      end
      S_P1_RD: begin
        ent_re  = 1'b1;
        state_d = S_P1_CHK;
      end
      S_P1_CHK: begin
        if (pub_match) begin
          lastk_d = idx_q;
          any_d   = 1'b1;
        end
        if (idx_p1 == cnt_x) begin
          idx_d = '0;
          if (any_q || pub_match) begin
            state_d = S_P2_RD;
          end else begin
            rc_d    = RC_NOMATCH;
            state_d = S_EMIT;
          end
        end else begin
          idx_d   = idx_p1[CNT_W-1:0];
          state_d = S_P1_RD;
        end
      end
      S_P2_RD: begin
        ent_re  = 1'b1;
        state_d = S_P2_CHK;
      end
      S_P2_CHK: begin
        if (!pub_match) begin
          idx_d   = idx_p1[CNT_W-1:0];
          state_d = S_P2_RD;
        end else if (out_free) begin
          out_load = 1'b1;
          out_d    = '{result_code:    RC_DELIVERY,
                       target_id:      ent_rdata.id,
                       target_handler: ent_rdata.hnd,
                       topic_word:     topic_word,
                       delivered_data: req_q.payload,
                       last:           (idx_q == lastk_q)};
          if (idx_q == lastk_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_p1[CNT_W-1:0];
            state_d = S_P2_RD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{result_code:    rc_q,
                       target_id:      8'd0,
                       target_handler: 4'd0,
                       topic_word:     topic_word,
                       delivered_data: req_data,
                       last:           1'b1};
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cnt_we) begin
        vld_q[tix] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    lastk_q <= lastk_d;
    any_q   <= any_d;
    rc_q    <= rc_d;
    base_q  <= base_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TSDT_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni,
                    in_accept && (in_i.mode != MODE_IGNORED), state_q == S_CNT,
                    "accepted request did not start the sequencer")
  `TSDT_ASSERT_NOW(a_load_free, clk_i, rst_ni, out_load, !out_valid_q || !out_stall_i,
                   "result loaded over a waiting result")
  `TSDT_ASSERT_NOW(a_count_range, clk_i, rst_ni, cnt_we, cnt_wdata <= SLOTS_C,
                   "topic count beyond slot limit")
  `TSDT_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_load && out_d.last, state_q == S_IDLE,
                    "sequencer busy after final result")

endmodule

`default_nettype wire
